// ----- hw/rtl/motor_command_frame_encoder_unit_macros.svh -----
// Assertion macros used by the checker file.
`ifndef MOTOR_COMMAND_FRAME_ENCODER_UNIT_MACROS_SVH
`define MOTOR_COMMAND_FRAME_ENCODER_UNIT_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define MCFE_ASSERT_PROP(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MCFE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/mcfe_pkg.sv -----
`timescale 1ns / 1ps

package mcfe_pkg;

    localparam logic [1:0] CMD_DUTY  = 2'd0;
    localparam logic [1:0] CMD_BRAKE = 2'd1;
    localparam logic [1:0] CMD_SERVO = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    localparam logic CFG_BRAKE  = 1'b0;
    localparam logic CFG_CENTER = 1'b1;

    localparam logic [7:0] OP_DUTY  = 8'd5;
    localparam logic [7:0] OP_BRAKE = 8'd7;
    localparam logic [7:0] OP_SERVO = 8'd12;

    localparam logic [7:0] START_BYTE = 8'h02;
    localparam logic [7:0] END_BYTE   = 8'h03;

    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [9:0]  SERVO_MAX  = 10'd1000;
    localparam logic [9:0]  CENTER_RST = 10'd500;

    localparam logic [3:0] LEN_WORD  = 4'd5;
    localparam logic [3:0] LEN_SERVO = 4'd3;

    typedef struct packed {
        logic [3:0]      len;
        logic [4:0][7:0] payload;
        logic            final_frame;
    } frame_desc_t;

    // CRC16-XMODEM update by one byte, one polynomial step per bit.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic frame_desc_t word_frame(input logic [7:0] op, input logic [31:0] w);
        frame_desc_t d;
        d.len         = LEN_WORD;
        d.payload[0]  = op;
        d.payload[1]  = w[31:24];
        d.payload[2]  = w[23:16];
        d.payload[3]  = w[15:8];
        d.payload[4]  = w[7:0];
        d.final_frame = 1'b0;
        return d;
    endfunction

    function automatic frame_desc_t servo_frame(input logic [9:0] pos);
        frame_desc_t d;
        d.len         = LEN_SERVO;
        d.payload[0]  = OP_SERVO;
        d.payload[1]  = {6'd0, pos[9:8]};
        d.payload[2]  = pos[7:0];
        d.payload[3]  = 8'd0;
        d.payload[4]  = 8'd0;
        d.final_frame = 1'b0;
        return d;
    endfunction

endpackage

// ----- hw/rtl/mcfe_frame_select.sv -----
`timescale 1ns / 1ps

module mcfe_frame_select (
    input  logic [1:0]           cmd,
    input  logic signed [31:0]   value,
    input  logic [1:0]           frame_idx,
    input  logic signed [31:0]   brake_cfg,
    input  logic [9:0]           center_cfg,
    output mcfe_pkg::frame_desc_t desc
);

    logic [9:0] servo_pos;
    logic [9:0] center_pos;

    always_comb
    begin
        if (value[31]) begin
            servo_pos = 10'd0;
        end
        else if (value > $signed({22'd0, mcfe_pkg::SERVO_MAX})) begin
            servo_pos = mcfe_pkg::SERVO_MAX;
        end
        else begin
            servo_pos = value[9:0];
        end

        center_pos = (center_cfg > mcfe_pkg::SERVO_MAX) ? mcfe_pkg::SERVO_MAX : center_cfg;
    end

    always_comb
    begin
        case (cmd)
            mcfe_pkg::CMD_DUTY:
            begin
                desc             = mcfe_pkg::word_frame(mcfe_pkg::OP_DUTY, value);
                desc.final_frame = 1'b1;
            end
            mcfe_pkg::CMD_BRAKE:
            begin
                desc             = mcfe_pkg::word_frame(mcfe_pkg::OP_BRAKE, value);
                desc.final_frame = 1'b1;
            end
            mcfe_pkg::CMD_SERVO:
            begin
                desc             = mcfe_pkg::servo_frame(servo_pos);
                desc.final_frame = 1'b1;
            end
            default:
            begin
                // Safe stop walks through three frames.
                case (frame_idx)
                    2'd0:    desc = mcfe_pkg::word_frame(mcfe_pkg::OP_DUTY, 32'd0);
                    2'd1:    desc = mcfe_pkg::word_frame(mcfe_pkg::OP_BRAKE, brake_cfg);
                    default:
                    begin
                        desc             = mcfe_pkg::servo_frame(center_pos);
                        desc.final_frame = 1'b1;
                    end
                endcase
            end
        endcase
    end

endmodule

// ----- hw/rtl/mcfe_byte_seq.sv -----
`timescale 1ns / 1ps

module mcfe_byte_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           cmd,
    input  logic signed [31:0]   value,
    input  logic signed [31:0]   brake_cfg,
    input  logic [9:0]           center_cfg,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte,
    output logic                 frame_end,
    output logic                 last
);

    logic                busy_reg, busy_next;
    logic [1:0]          cmd_reg, cmd_next;
    logic signed [31:0]  value_reg, value_next;
    logic [1:0]          frame_reg, frame_next;
    logic [3:0]          pos_reg, pos_next;
    logic [15:0]         crc_reg, crc_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_byte_reg, out_byte_next;
    logic                frame_end_reg, frame_end_next;
    logic                last_reg, last_next;

    mcfe_pkg::frame_desc_t desc;

    logic        advance;
    logic        accept;
    logic [3:0]  end_pos;
    logic        frame_done;
    logic        cmd_done;
    logic        is_payload;
    logic [2:0]  pidx;
    logic [7:0]  pl_byte;
    logic [7:0]  cur_byte;

    mcfe_frame_select u_sel (
        .cmd        (cmd_reg),
        .value      (value_reg),
        .frame_idx  (frame_reg),
        .brake_cfg  (brake_cfg),
        .center_cfg (center_cfg),
        .desc       (desc)
    );

    always_comb
    begin
        advance    = busy_reg && (!out_valid_reg || out_ready);
        end_pos    = desc.len + 4'd4;
        frame_done = (pos_reg == end_pos);
        cmd_done   = frame_done && desc.final_frame;
        // The next request is taken while the last byte moves to the output register.
        in_ready   = !busy_reg || (advance && cmd_done);
        accept     = in_valid && in_ready;
        is_payload = (pos_reg >= 4'd2) && (pos_reg < desc.len + 4'd2);
        pidx       = 3'(pos_reg - 4'd2);

        case (pidx)
            3'd0:    pl_byte = desc.payload[0];
            3'd1:    pl_byte = desc.payload[1];
            3'd2:    pl_byte = desc.payload[2];
            3'd3:    pl_byte = desc.payload[3];
            default: pl_byte = desc.payload[4];
        endcase

        if (pos_reg == 4'd0) begin
            cur_byte = mcfe_pkg::START_BYTE;
        end
        else if (pos_reg == 4'd1) begin
            cur_byte = {4'd0, desc.len};
        end
        else if (is_payload) begin
            cur_byte = pl_byte;
        end
        else if (pos_reg == desc.len + 4'd2) begin
            cur_byte = crc_reg[15:8];
        end
        else if (pos_reg == desc.len + 4'd3) begin
            cur_byte = crc_reg[7:0];
        end
        else begin
            cur_byte = mcfe_pkg::END_BYTE;
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        cmd_next       = cmd_reg;
        value_next     = value_reg;
        frame_next     = frame_reg;
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        frame_end_next = frame_end_reg;
        last_next      = last_reg;

        if (advance) begin
            out_valid_next = 1'b1;
            out_byte_next  = cur_byte;
            frame_end_next = frame_done;
            last_next      = cmd_done;

            if (pos_reg == 4'd0) begin
                crc_next = 16'd0;
            end
            else if (is_payload) begin
                crc_next = mcfe_pkg::crc_byte(crc_reg, pl_byte);
            end

            if (cmd_done) begin
                busy_next = 1'b0;
            end
            else if (frame_done) begin
                frame_next = frame_reg + 2'd1;
                pos_next   = 4'd0;
            end
            else begin
                pos_next = pos_reg + 4'd1;
            end
        end
        else if (out_ready) begin
            out_valid_next = 1'b0;
        end

        if (accept) begin
            busy_next  = 1'b1;
            cmd_next   = cmd;
            value_next = value;
            frame_next = 2'd0;
            pos_next   = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg      <= 1'b0;
            frame_reg     <= 2'd0;
            pos_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else begin
            busy_reg      <= busy_next;
            frame_reg     <= frame_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        value_reg     <= value_next;
        crc_reg       <= crc_next;
        out_byte_reg  <= out_byte_next;
        frame_end_reg <= frame_end_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign frame_end = frame_end_reg;
    assign last      = last_reg;

endmodule

// ----- hw/rtl/motor_command_frame_encoder_unit.sv -----
`timescale 1ns / 1ps

// Latency: the start byte of a frame reaches the output register at the edge after the
// request is taken, or later while a held output byte waits for out_ready.
// Throughput: one frame byte per cycle unless out_ready stalls; a request sends 10 bytes
// (duty, brake), 8 (servo) or 28 (safe stop) from one sequencer with a CRC step per byte.
// Reset clears the sequencer and output valid, sets the brake register to 0 and the
// center register to 500.
module motor_command_frame_encoder_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic                 cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           cmd,
    input  logic signed [31:0]   value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte,
    output logic                 frame_end,
    output logic                 last
);

    logic signed [31:0] brake_cfg_reg, brake_cfg_next;
    logic [9:0]         center_cfg_reg, center_cfg_next;

    always_comb
    begin
        brake_cfg_next  = brake_cfg_reg;
        center_cfg_next = center_cfg_reg;
        if (cfg_write) begin
            case (cfg_index)
                mcfe_pkg::CFG_BRAKE:  brake_cfg_next  = cfg_data;
                mcfe_pkg::CFG_CENTER: center_cfg_next = cfg_data[9:0];
                default:              brake_cfg_next  = brake_cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            brake_cfg_reg  <= 32'sd0;
            center_cfg_reg <= mcfe_pkg::CENTER_RST;
        end
        else begin
            brake_cfg_reg  <= brake_cfg_next;
            center_cfg_reg <= center_cfg_next;
        end
    end

    mcfe_byte_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .value      (value),
        .brake_cfg  (brake_cfg_reg),
        .center_cfg (center_cfg_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .frame_end  (frame_end),
        .last       (last)
    );

endmodule

// ----- hw/rtl/mcfe_checker.sv -----
`timescale 1ns / 1ps

`include "motor_command_frame_encoder_unit_macros.svh"

module mcfe_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [7:0]          out_byte,
    input logic                frame_end,
    input logic                last
);

    logic       out_stall;
    logic [9:0] out_word;
    logic       is_end_byte;

    assign out_stall   = out_valid && !out_ready;
    assign out_word    = {out_byte, frame_end, last};
    assign is_end_byte = (out_byte == mcfe_pkg::END_BYTE);

    // A stalled output byte holds until it is taken.
    `MCFE_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word), "stalled byte changed")

    // The final byte of a request is always the end byte of a frame.
    `MCFE_ASSERT_PROP(a_last_is_end, !(out_valid && last) || frame_end, "last byte is not a frame end")

    `MCFE_ASSERT_PROP(a_end_byte, !(out_valid && frame_end) || is_end_byte, "frame end without end byte")

    // A taken request shows output valid after the busy flag and then the output register are updated.
    `MCFE_ASSERT_PROP(a_accept_out, (in_valid && in_ready) |-> ##2 out_valid, "no output after request")

endmodule

bind motor_command_frame_encoder_unit mcfe_checker u_mcfe_checker (.*);

// ----- sim/motor_command_frame_encoder_unit_tb.sv -----
`timescale 1ns / 1ps

module motor_command_frame_encoder_unit_tb;

    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_CYCLES     = 400;
    localparam int ITEMS_PER_PHASE = 55;
    localparam int PHASE_COUNT     = 8;
    localparam int DIRECTED_ROWS   = 21;

    typedef struct packed {
        logic [7:0] data;
        logic       frame_end;
        logic       last;
    } frame_byte_t;

    // A row with typed set carries its expected frame word, so no prediction is run for it.
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
        logic        typed;
        logic [31:0] word;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic               cfg_index = 1'b0;
    logic [31:0]        cfg_data = 32'd0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         cmd = 2'd0;
    logic signed [31:0] value = 32'sd0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [7:0]         out_byte;
    logic               frame_end;
    logic               last;

    frame_byte_t frame_bytes_due[$];
    logic [31:0] brake_mirror = 32'd0;
    logic [9:0]  center_mirror = mcfe_pkg::CENTER_RST;
    int          mismatches = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        hold_toggle = 1'b0;
    logic        hold_seen = 1'b0;
    int          hold_left = 0;
    int          quiet_cycles = 0;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{mcfe_pkg::CMD_DUTY,  32'h0000_0000, 1'b1, 32'h0000_0000},
        '{mcfe_pkg::CMD_DUTY,  32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
        '{mcfe_pkg::CMD_DUTY,  32'h8000_0000, 1'b1, 32'h8000_0000},
        '{mcfe_pkg::CMD_DUTY,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
        '{mcfe_pkg::CMD_BRAKE, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{mcfe_pkg::CMD_BRAKE, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
        '{mcfe_pkg::CMD_BRAKE, 32'h8000_0000, 1'b1, 32'h8000_0000},
        '{mcfe_pkg::CMD_BRAKE, 32'h1234_5678, 1'b0, 32'h0000_0000},
        '{mcfe_pkg::CMD_SERVO, 32'd0,         1'b1, 32'd0},
        '{mcfe_pkg::CMD_SERVO, 32'd1000,      1'b1, 32'd1000},
        '{mcfe_pkg::CMD_SERVO, 32'd1001,      1'b1, 32'd1000},
        '{mcfe_pkg::CMD_SERVO, 32'hFFFF_FFFF, 1'b1, 32'd0},
        '{mcfe_pkg::CMD_SERVO, 32'h7FFF_FFFF, 1'b1, 32'd1000},
        '{mcfe_pkg::CMD_SERVO, 32'h8000_0000, 1'b1, 32'd0},
        '{mcfe_pkg::CMD_SERVO, 32'd500,       1'b1, 32'd500},
        '{mcfe_pkg::CMD_SERVO, 32'd999,       1'b0, 32'd0},
        '{mcfe_pkg::CMD_STOP,  32'h0000_0000, 1'b0, 32'd0},
        '{mcfe_pkg::CMD_STOP,  32'hFFFF_FFFF, 1'b0, 32'd0},
        '{mcfe_pkg::CMD_STOP,  32'h5A5A_5A5A, 1'b0, 32'd0},
        '{mcfe_pkg::CMD_DUTY,  32'hA5A5_A5A5, 1'b0, 32'd0},
        '{mcfe_pkg::CMD_BRAKE, 32'h5A5A_5A5A, 1'b0, 32'd0}
    };

    motor_command_frame_encoder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .frame_end (frame_end),
        .last      (last)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 7; k >= 0; k--)
        begin
            fb = c[15] ^ b[k];
            c = c << 1;
            if (fb)
            begin
                c = c ^ mcfe_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    // Appends one expected byte at the tail of the queue.
    function automatic void queue_byte(input logic [7:0] data, input logic fe,
                                       input logic closes);
        frame_byte_t b;
        b.data      = data;
        b.frame_end = fe;
        b.last      = closes;
        frame_bytes_due.insert(frame_bytes_due.size(), b);
    endfunction

    // Queues the bytes of one frame; a three byte payload carries the low half of word.
    function automatic void push_frame(input logic [7:0] opcode, input logic [31:0] word,
                                       input int len, input logic closes_request);
        logic [7:0]  body [5];
        logic [15:0] crc;
        body[0] = opcode;
        if (len == 5)
        begin
            body[1] = word[31:24];
            body[2] = word[23:16];
            body[3] = word[15:8];
            body[4] = word[7:0];
        end
        else
        begin
            body[1] = word[15:8];
            body[2] = word[7:0];
        end
        crc = 16'h0000;
        queue_byte(mcfe_pkg::START_BYTE, 1'b0, 1'b0);
        queue_byte(8'(len), 1'b0, 1'b0);
        for (int i = 0; i < len; i++)
        begin
            queue_byte(body[i], 1'b0, 1'b0);
            crc = crc_update(crc, body[i]);
        end
        queue_byte(crc[15:8], 1'b0, 1'b0);
        queue_byte(crc[7:0], 1'b0, 1'b0);
        queue_byte(mcfe_pkg::END_BYTE, 1'b1, closes_request);
    endfunction

    function automatic logic [31:0] clamp_position(input int pos);
        if (pos < 0)
        begin
            return 32'd0;
        end
        if (pos > 1000)
        begin
            return 32'd1000;
        end
        return 32'(pos);
    endfunction

    function automatic void predict_frames(input logic [1:0] kind, input logic [31:0] v);
        case (kind)
            mcfe_pkg::CMD_DUTY:  push_frame(mcfe_pkg::OP_DUTY, v, 5, 1'b1);
            mcfe_pkg::CMD_BRAKE: push_frame(mcfe_pkg::OP_BRAKE, v, 5, 1'b1);
            mcfe_pkg::CMD_SERVO:
                push_frame(mcfe_pkg::OP_SERVO, clamp_position(int'($signed(v))), 3, 1'b1);
            default:
            begin
                push_frame(mcfe_pkg::OP_DUTY, 32'd0, 5, 1'b0);
                push_frame(mcfe_pkg::OP_BRAKE, brake_mirror, 5, 1'b0);
                push_frame(mcfe_pkg::OP_SERVO, clamp_position(int'(center_mirror)), 3, 1'b1);
            end
        endcase
    endfunction

    function automatic void expect_typed_frame(input logic [1:0] kind, input logic [31:0] word);
        if (kind == mcfe_pkg::CMD_SERVO)
        begin
            push_frame(mcfe_pkg::OP_SERVO, word, 3, 1'b1);
        end
        else
        begin
            push_frame((kind == mcfe_pkg::CMD_DUTY) ? mcfe_pkg::OP_DUTY : mcfe_pkg::OP_BRAKE,
                       word, 5, 1'b1);
        end
    endfunction

    function automatic logic [31:0] random_value(input logic [1:0] kind);
        int pick;
        pick = $urandom_range(9);
        if (kind == mcfe_pkg::CMD_SERVO)
        begin
            case (pick)
                0, 1, 2, 3, 4, 5: return $urandom_range(1000);
                6:       return $urandom_range(1100, 1001);
                7:       return -$urandom_range(100, 1);
                8:       return ($urandom_range(1) != 0) ? 32'd1000 : 32'd0;
                default: return $urandom;
            endcase
        end
        case (pick)
            0, 1, 2, 3, 4, 5: return $urandom;
            6, 7:    return $urandom_range(2000) - 1000;
            8:       return ($urandom_range(1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
        endcase
    endfunction

    // Called at a clock edge; returns at the edge that takes the request, valid still high.
    task automatic send_request(input logic [1:0] kind, input logic [31:0] v,
                                input logic typed, input logic [31:0] word);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= kind;
        value <= v;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        if (typed)
        begin
            expect_typed_frame(kind, word);
        end
        else
        begin
            predict_frames(kind, v);
        end
    endtask

    task automatic wait_for_frames;
        while (frame_bytes_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_register(input logic idx, input logic [31:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == mcfe_pkg::CFG_BRAKE)
        begin
            brake_mirror = data;
        end
        else
        begin
            center_mirror = data[9:0];
        end
    endtask

    // The receiver runs on its own; a toggle of hold_toggle starts a long stall.
    always @(posedge clk)
    begin
        if (hold_toggle != hold_seen)
        begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        frame_byte_t due;
        if (rst_n && out_valid && out_ready)
        begin
            if (frame_bytes_due.size() == 0)
            begin
                $error("unexpected frame byte %0h with no request pending", out_byte);
                mismatches++;
            end
            else
            begin
                due = frame_bytes_due.pop_front();
                if (out_byte !== due.data)
                begin
                    $error("out_byte: expected %0h, actual %0h", due.data, out_byte);
                    mismatches++;
                end
                if (frame_end !== due.frame_end)
                begin
                    $error("frame_end: expected %0b, actual %0b", due.frame_end, frame_end);
                    mismatches++;
                end
                if (last !== due.last)
                begin
                    $error("last: expected %0b, actual %0b", due.last, last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("motor_command_frame_encoder_unit_tb failed");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] brake_setting;
        logic [9:0]  center_setting;
        logic [1:0]  kind;

        tx_idle_pct = 20;
        rx_idle_pct = 68;
        repeat (10)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers still hold their reset values here.
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            send_request(directed_rows[r].kind, directed_rows[r].value,
                         directed_rows[r].typed, directed_rows[r].word);
        end
        in_valid <= 1'b0;
        wait_for_frames();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0:
                begin
                    brake_setting = 32'h7FFF_FFFF;
                    center_setting = 10'd0;
                end
                1:
                begin
                    brake_setting = 32'h8000_0000;
                    center_setting = 10'd1023;
                end
                2:
                begin
                    brake_setting = $urandom;
                    center_setting = mcfe_pkg::SERVO_MAX;
                end
                3:
                begin
                    brake_setting = 32'hFFFF_FFFF;
                    center_setting = 10'd1001;
                end
                4:
                begin
                    brake_setting = $urandom;
                    center_setting = 10'($urandom_range(1023));
                end
                5:
                begin
                    brake_setting = 32'd0;
                    center_setting = mcfe_pkg::CENTER_RST;
                end
                6:
                begin
                    brake_setting = $urandom;
                    center_setting = 10'($urandom_range(1000));
                end
                default:
                begin
                    brake_setting = $urandom;
                    center_setting = 10'd1012;
                end
            endcase
            write_register(mcfe_pkg::CFG_BRAKE, brake_setting);
            write_register(mcfe_pkg::CFG_CENTER, {22'd0, center_setting});

            if (p < 2)
            begin
                tx_idle_pct = 20;
                rx_idle_pct = 68;
            end
            else if (p < 5)
            begin
                tx_idle_pct = 68;
                rx_idle_pct = 20;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            // With no idling, a long receiver stall backs the block up into its input.
            if (p == 5)
            begin
                hold_toggle <= ~hold_toggle;
            end

            @(posedge clk);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                kind = 2'($urandom_range(3));
                send_request(kind, random_value(kind), 1'b0, 32'd0);
            end
            in_valid <= 1'b0;
            wait_for_frames();
        end

        repeat (20)
        begin
            @(posedge clk);
        end
        if (mismatches == 0 && frame_bytes_due.size() == 0)
        begin
            $display("motor_command_frame_encoder_unit_tb passed");
        end
        else
        begin
            $display("motor_command_frame_encoder_unit_tb failed");
        end
        $finish;
    end

endmodule
